@@ rtl/core/sts_pkg.sv @@
// Shared types and constants for the source token scanner.
// Holds the scanner state encoding, token kind codes, character codes,
// the result record and the reserved-word table. No dependencies.
package sts_pkg;

	// Reserved-word table size
	localparam int KW_TABLE = 14;

	// Result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	// Token kinds
	localparam logic [5:0] K_ID     = 6'd0;
	localparam logic [5:0] K_NUM    = 6'd1;
	localparam logic [5:0] K_CHR    = 6'd2;
	localparam logic [5:0] K_STR    = 6'd3;
	localparam logic [5:0] K_COM    = 6'd4;
	localparam logic [5:0] K_PLUS   = 6'd5;
	localparam logic [5:0] K_MINUS  = 6'd6;
	localparam logic [5:0] K_ASSIGN = 6'd7;
	localparam logic [5:0] K_TIMES  = 6'd8;
	localparam logic [5:0] K_DIV    = 6'd9;
	localparam logic [5:0] K_MOD    = 6'd10;
	localparam logic [5:0] K_LT     = 6'd11;
	localparam logic [5:0] K_LTEQ   = 6'd12;
	localparam logic [5:0] K_GT     = 6'd13;
	localparam logic [5:0] K_GTEQ   = 6'd14;
	localparam logic [5:0] K_EQ     = 6'd15;
	localparam logic [5:0] K_NEQ    = 6'd16;
	localparam logic [5:0] K_LPAREN = 6'd17;
	localparam logic [5:0] K_RPAREN = 6'd18;
	localparam logic [5:0] K_LBRACE = 6'd19;
	localparam logic [5:0] K_RBRACE = 6'd20;
	localparam logic [5:0] K_COMMA  = 6'd21;
	localparam logic [5:0] K_SEMI   = 6'd22;
	localparam logic [5:0] K_KW0    = 6'd23;
	localparam logic [5:0] K_END    = 6'd37;
	localparam logic [5:0] K_ERR    = 6'd38;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [4:0] {
		S_START, S_ID, S_NUM, S_STR, S_CBEG, S_CEND, S_EQ, S_NEQ, S_LT, S_GT,
		S_SLASH, S_LCOM, S_BCOM, S_BSTAR, S_READY
	} scan_state_t;

	typedef struct packed {
		logic [5:0] kind;
		logic [5:0] length;
		logic [7:0] err_char;
		logic       last;
	} result_t;

	// Reserved word text, left-justified, first character in the top byte
	function automatic logic [63:0] kw_word(input logic [3:0] idx);
		logic [63:0] w;
		case (idx)
			4'd0:    w = {"bool", 32'd0};
			4'd1:    w = {"char", 32'd0};
			4'd2:    w = {"const", 24'd0};
			4'd3:    w = {"string", 16'd0};
			4'd4:    w = {"int", 40'd0};
			4'd5:    w = {"if", 48'd0};
			4'd6:    w = {"else", 32'd0};
			4'd7:    w = {"while", 24'd0};
			4'd8:    w = {"read", 32'd0};
			4'd9:    w = {"print", 24'd0};
			4'd10:   w = {"println", 8'd0};
			4'd11:   w = {"main", 32'd0};
			4'd12:   w = {"FALSE", 24'd0};
			4'd13:   w = {"TRUE", 32'd0};
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd6, 4'd8, 4'd11, 4'd13: n = 4'd4;
			4'd2, 4'd7, 4'd9, 4'd12:              n = 4'd5;
			4'd3:                                 n = 4'd6;
			4'd4:                                 n = 4'd3;
			4'd5:                                 n = 4'd2;
			4'd10:                                n = 4'd7;
			default:                              n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

endpackage

@@ rtl/core/sts_in_if.sv @@
// Character input channel of the source token scanner.
// Valid/ready handshake with one source byte or an end-of-input mark.
interface sts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source(output valid, char_code, end_of_input, input ready);
	modport sink(input valid, char_code, end_of_input, output ready);
endinterface

@@ rtl/core/sts_out_if.sv @@
// Token output channel of the source token scanner.
// Valid/ready handshake carrying kind, length, error character and run end.
interface sts_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] token_kind;
	logic [5:0] token_length;
	logic [7:0] error_char;
	logic       last_of_run;

	modport source(output valid, token_kind, token_length, error_char, last_of_run,
		input ready);
	modport sink(input valid, token_kind, token_length, error_char, last_of_run,
		output ready);
endinterface

@@ rtl/core/source_token_scanner_unit.sv @@
// Source token scanner: one character (or end mark) per transfer, 0..2 tokens out.
// Path: input register, then the result queue, then the token output.
// Throughput: one input per cycle; limited by the 4-entry result queue, so a
// run of two-token inputs or a stalled output slows intake to the drain rate.
// Reset (arst_n low, asynchronous): start state, empty lexeme, empty queue.
// Depends on sts_pkg, sts_in_if, sts_out_if, sts_step, sts_rq.
module source_token_scanner_unit #(
	parameter int MAX_LEXEME    = 32,
	parameter int KEYWORD_COUNT = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	sts_in_if.sink    char_in,
	sts_out_if.source token_out
);
	import sts_pkg::*;

	localparam int CW = $clog2(MAX_LEXEME + 1);
	localparam logic [KEYWORD_COUNT-1:0] KW_ALL = (KEYWORD_COUNT >= KW_TABLE) ?
		KEYWORD_COUNT'((64'd1 << KW_TABLE) - 64'd1) : '1;

	// Input register: one character waits here until the queue has room
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// Scanner state
	scan_state_t              st_q;
	logic [CW-1:0]            cnt_q;
	logic [KEYWORD_COUNT-1:0] cand_q;
	logic [5:0]               pend_q;

	// Step results
	scan_state_t              nst;
	logic [CW-1:0]            ncnt;
	logic [KEYWORD_COUNT-1:0] ncand;
	logic [5:0]               npend;
	logic [1:0]               n_res;
	result_t                  res0;
	result_t                  res1;

	logic [RQ_AW:0] free;
	logic           fire;

	// Advance the scanner only when every token of this character fits in the queue
	assign fire          = valid_s1 && ((RQ_AW + 1)'(n_res) <= free);
	assign char_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	// Payload holds while stalled; no reset needed
	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
			eoi_s1  <= char_in.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_START;
			cnt_q  <= '0;
			cand_q <= KW_ALL;
			pend_q <= K_ID;
		end else if (fire) begin
			st_q   <= nst;
			cnt_q  <= ncnt;
			cand_q <= ncand;
			pend_q <= npend;
		end
	end

	sts_step #(
		.MAX_LEXEME   (MAX_LEXEME),
		.KEYWORD_COUNT(KEYWORD_COUNT)
	) u_step (
		.st   (st_q),
		.cnt  (cnt_q),
		.cand (cand_q),
		.pend (pend_q),
		.ch   (char_s1),
		.eoi  (eoi_s1),
		.nst  (nst),
		.ncnt (ncnt),
		.ncand(ncand),
		.npend(npend),
		.n_res(n_res),
		.res0 (res0),
		.res1 (res1)
	);

	// Drop the step's tokens into the queue only on a transfer out of the input register
	sts_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (fire ? n_res : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.free     (free),
		.token_out(token_out)
	);

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi_s1 |=> st_q == S_START && cnt_q == '0 && cand_q == KW_ALL)
		else $error("end of input did not return scanner to start");

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_START |-> cnt_q == '0)
		else $error("lexeme count nonzero in start state");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_LEXEME))
		else $error("lexeme count beyond saturation");

	a_tokens_visible: assert property (@(posedge clk) disable iff (!arst_n)
		fire && n_res != 2'd0 |=> token_out.valid)
		else $error("pushed token not presented");

endmodule

@@ rtl/core/sts_step.sv @@
// Combinational scanner step: next DFA state, lexeme count, keyword mask
// and up to two tokens for one character. Depends on sts_pkg.
module sts_step #(
	parameter int MAX_LEXEME    = 32,
	parameter int KEYWORD_COUNT = 14,
	localparam int CW = $clog2(MAX_LEXEME + 1)
) (
	input  sts_pkg::scan_state_t     st,
	input  logic [CW-1:0]            cnt,
	input  logic [KEYWORD_COUNT-1:0] cand,
	input  logic [5:0]               pend,
	input  logic [7:0]               ch,
	input  logic                     eoi,
	output sts_pkg::scan_state_t     nst,
	output logic [CW-1:0]            ncnt,
	output logic [KEYWORD_COUNT-1:0] ncand,
	output logic [5:0]               npend,
	output logic [1:0]               n_res,
	output sts_pkg::result_t         res0,
	output sts_pkg::result_t         res1
);
	import sts_pkg::*;

	localparam logic [KEYWORD_COUNT-1:0] KW_ALL = (KEYWORD_COUNT >= KW_TABLE) ?
		KEYWORD_COUNT'((64'd1 << KW_TABLE) - 64'd1) : '1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEXEME);

	function automatic logic [KEYWORD_COUNT-1:0] kw_filter(
		input logic [KEYWORD_COUNT-1:0] m, input logic [CW-1:0] pos, input logic [7:0] c);
		logic [KEYWORD_COUNT-1:0] r;
		logic [63:0]              w;
		logic [3:0]               wl;
		logic [2:0]               p;
		r = '0;
		p = pos[2:0];
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			if (i < KW_TABLE) begin
				w = kw_word(4'(i));
				wl = kw_len(4'(i));
				r[i] = m[i] && (pos < CW'(wl)) && (w[8*(7-int'(p)) +: 8] == c);
			end
		end
		return r;
	endfunction

	function automatic logic [5:0] len6(input logic [CW-1:0] n);
		logic [7:0] w;
		w = 8'(n);
		return w[5:0];
	endfunction

	logic [CW-1:0]            sv_cnt;
	logic [KEYWORD_COUNT-1:0] sv_cand;
	logic [CW-1:0]            sat_p1;
	logic [5:0]               id_kind;

	scan_state_t              fs_st;
	logic [CW-1:0]            fs_cnt;
	logic [KEYWORD_COUNT-1:0] fs_cand;
	logic [5:0]               fs_pend;
	logic                     fs_err;

	logic    prim_v;
	result_t prim;
	logic    restart;
	result_t err_tok;
	result_t end_tok;
	logic    second;

	// Append the current character to the lexeme
	always_comb begin
		if (cnt >= MAX_CNT) begin
			sv_cnt  = cnt;
			sv_cand = '0;
		end else begin
			sv_cnt  = cnt + 1'b1;
			sv_cand = kw_filter(cand, cnt, ch);
		end
		sat_p1 = (cnt < MAX_CNT) ? cnt + 1'b1 : MAX_CNT;
	end

	// Identifier or reserved word: the highest surviving candidate of exact length wins
	always_comb begin
		id_kind = K_ID;
		for (int i = 0; i < KEYWORD_COUNT; i++) begin
			if (i < KW_TABLE && cand[i] && cnt == CW'(kw_len(4'(i))))
				id_kind = K_KW0 + 6'(i);
		end
	end

	// Start-state scan of the current character
	always_comb begin
		fs_st   = S_START;
		fs_cnt  = '0;
		fs_cand = KW_ALL;
		fs_pend = K_ID;
		fs_err  = 1'b0;
		if (ch inside {CH_SP, CH_TAB, CH_NL}) begin
			fs_st = S_START;
		end else if (is_alpha(ch) || is_digit(ch)) begin
			fs_st   = is_alpha(ch) ? S_ID : S_NUM;
			fs_cnt  = CW'(1);
			fs_cand = kw_filter(KW_ALL, '0, ch);
		end else if (ch == CH_DQUOTE) begin
			fs_st = S_STR;
		end else if (ch == CH_SQUOTE) begin
			fs_st = S_CBEG;
		end else begin
			fs_cnt  = CW'(1);
			fs_cand = kw_filter(KW_ALL, '0, ch);
			fs_st   = S_READY;
			case (ch)
				CH_EQ:     fs_st = S_EQ;
				CH_BANG:   fs_st = S_NEQ;
				CH_LT:     fs_st = S_LT;
				CH_GT:     fs_st = S_GT;
				CH_SLASH:  fs_st = S_SLASH;
				CH_PLUS:   fs_pend = K_PLUS;
				CH_MINUS:  fs_pend = K_MINUS;
				CH_STAR:   fs_pend = K_TIMES;
				CH_PCT:    fs_pend = K_MOD;
				CH_LPAREN: fs_pend = K_LPAREN;
				CH_RPAREN: fs_pend = K_RPAREN;
				CH_LBRACE: fs_pend = K_LBRACE;
				CH_RBRACE: fs_pend = K_RBRACE;
				CH_COMMA:  fs_pend = K_COMMA;
				CH_SEMI:   fs_pend = K_SEMI;
				default: begin
					fs_st   = S_START;
					fs_cnt  = '0;
					fs_cand = KW_ALL;
					fs_err  = 1'b1;
				end
			endcase
		end
	end

	// Token emitted by the current state, and whether the character is rescanned
	always_comb begin
		prim_v  = 1'b0;
		prim    = '{kind: K_ID, length: len6(cnt), err_char: 8'd0, last: 1'b0};
		restart = 1'b0;
		if (eoi) begin
			prim_v = 1'b1;
			case (st)
				S_ID:    prim.kind = id_kind;
				S_NUM:   prim.kind = K_NUM;
				S_EQ:    prim.kind = K_ASSIGN;
				S_LT:    prim.kind = K_LT;
				S_GT:    prim.kind = K_GT;
				S_SLASH: prim.kind = K_DIV;
				S_LCOM:  prim.kind = K_COM;
				S_READY: prim.kind = pend;
				S_STR, S_CBEG, S_CEND, S_NEQ, S_BCOM, S_BSTAR: prim.kind = K_ERR;
				default: prim_v = 1'b0;
			endcase
		end else begin
			case (st)
				S_ID: begin
					if (!(is_alpha(ch) || is_digit(ch))) begin
						prim_v    = 1'b1;
						prim.kind = id_kind;
						restart   = 1'b1;
					end
				end
				S_NUM: begin
					if (is_alpha(ch)) begin
						prim_v = 1'b1;
						prim   = '{kind: K_ERR, length: len6(sat_p1), err_char: ch, last: 1'b0};
						restart = 1'b1;
					end else if (!is_digit(ch)) begin
						prim_v    = 1'b1;
						prim.kind = K_NUM;
						restart   = 1'b1;
					end
				end
				S_CEND: begin
					if (ch != CH_SQUOTE) begin
						prim_v = 1'b1;
						prim   = '{kind: K_ERR, length: len6(sat_p1), err_char: ch, last: 1'b0};
						restart = 1'b1;
					end
				end
				S_EQ, S_NEQ, S_LT, S_GT: begin
					prim_v = 1'b1;
					if (ch == CH_EQ) begin
						prim.length = len6(sat_p1);
						case (st)
							S_EQ:    prim.kind = K_EQ;
							S_NEQ:   prim.kind = K_NEQ;
							S_LT:    prim.kind = K_LTEQ;
							default: prim.kind = K_GTEQ;
						endcase
					end else begin
						restart = 1'b1;
						case (st)
							S_EQ:    prim.kind = K_ASSIGN;
							S_LT:    prim.kind = K_LT;
							S_GT:    prim.kind = K_GT;
							default: prim = '{kind: K_ERR, length: len6(sat_p1), err_char: ch,
								last: 1'b0};
						endcase
					end
				end
				S_SLASH: begin
					if (ch != CH_SLASH && ch != CH_STAR) begin
						prim_v    = 1'b1;
						prim.kind = K_DIV;
						restart   = 1'b1;
					end
				end
				S_LCOM: begin
					if (ch == CH_NL) begin
						prim_v    = 1'b1;
						prim.kind = K_COM;
						restart   = 1'b1;
					end
				end
				S_READY: begin
					prim_v    = 1'b1;
					prim.kind = pend;
					restart   = 1'b1;
				end
				S_STR, S_CBEG, S_BCOM, S_BSTAR: begin
					restart = 1'b0;
				end
				default: restart = 1'b1;
			endcase
		end
	end

	// Pack up to two results, flag the final one
	always_comb begin
		err_tok = '{kind: K_ERR, length: 6'd1, err_char: ch, last: 1'b0};
		end_tok = '{kind: K_END, length: 6'd0, err_char: 8'd0, last: 1'b0};
		second  = restart && fs_err;
		res0    = prim;
		res1    = err_tok;
		n_res   = 2'd0;
		if (eoi) begin
			if (prim_v) begin
				res1  = end_tok;
				n_res = 2'd2;
			end else begin
				res0  = end_tok;
				n_res = 2'd1;
			end
		end else if (prim_v) begin
			n_res = second ? 2'd2 : 2'd1;
		end else if (second) begin
			res0  = err_tok;
			n_res = 2'd1;
		end
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// Next state
	always_comb begin
		nst   = st;
		ncnt  = cnt;
		ncand = cand;
		npend = pend;
		if (eoi) begin
			nst   = S_START;
			ncnt  = '0;
			ncand = KW_ALL;
			npend = K_ID;
		end else if (restart) begin
			nst   = fs_st;
			ncnt  = fs_cnt;
			ncand = fs_cand;
			npend = fs_pend;
		end else begin
			case (st)
				S_ID, S_NUM, S_LCOM: begin
					ncnt  = sv_cnt;
					ncand = sv_cand;
				end
				S_STR: begin
					if (ch == CH_DQUOTE) begin
						nst   = S_READY;
						npend = K_STR;
					end else begin
						ncnt  = sv_cnt;
						ncand = sv_cand;
					end
				end
				S_CBEG: begin
					ncnt  = sv_cnt;
					ncand = sv_cand;
					nst   = S_CEND;
				end
				S_CEND: begin
					nst   = S_READY;
					npend = K_CHR;
				end
				S_EQ, S_NEQ, S_LT, S_GT: begin
					// pair consumed, back to an empty start state
					nst   = S_START;
					ncnt  = '0;
					ncand = KW_ALL;
					npend = K_ID;
				end
				S_SLASH: begin
					ncnt  = sv_cnt;
					ncand = sv_cand;
					nst   = (ch == CH_SLASH) ? S_LCOM : S_BCOM;
				end
				S_BCOM: begin
					ncnt  = sv_cnt;
					ncand = sv_cand;
					if (ch == CH_STAR)
						nst = S_BSTAR;
				end
				S_BSTAR: begin
					ncnt  = sv_cnt;
					ncand = sv_cand;
					if (ch == CH_SLASH) begin
						nst   = S_READY;
						npend = K_COM;
					end else if (ch != CH_STAR) begin
						nst = S_BCOM;
					end
				end
				default: nst = st;
			endcase
		end
	end

endmodule

@@ rtl/core/sts_rq.sv @@
// Result queue of the source token scanner: takes up to two tokens a cycle,
// hands out one per transfer. Depends on sts_pkg and sts_out_if.
module sts_rq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_n,
	input  sts_pkg::result_t       push0,
	input  sts_pkg::result_t       push1,
	output logic [sts_pkg::RQ_AW:0] free,
	sts_out_if.source              token_out
);
	import sts_pkg::*;

	localparam logic [RQ_AW-1:0] ONE = RQ_AW'(1);

	result_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] head_q;
	logic [RQ_AW-1:0] tail_q;
	logic [RQ_AW:0]   count_q;
	logic             pop;

	assign pop  = token_out.valid && token_out.ready;
	assign free = (RQ_AW + 1)'(RQ_DEPTH) - count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + ONE;
			tail_q  <= tail_q + RQ_AW'(push_n);
			count_q <= count_q + (RQ_AW + 1)'(push_n) - (RQ_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[tail_q] <= push0;
		if (push_n == 2'd2)
			mem_q[tail_q + ONE] <= push1;
	end

	assign token_out.valid        = (count_q != '0);
	assign token_out.token_kind   = mem_q[head_q].kind;
	assign token_out.token_length = mem_q[head_q].length;
	assign token_out.error_char   = mem_q[head_q].err_char;
	assign token_out.last_of_run  = mem_q[head_q].last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RQ_AW + 1)'(RQ_DEPTH))
		else $error("result queue over capacity");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(RQ_AW + 1)'(push_n) <= free)
		else $error("push exceeds free entries");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on transfer");

endmodule

@@ test/sts_token_checker.sv @@
// Token checker for the source token scanner testbench.
// Watches both channels, predicts the tokens of every accepted character
// and compares them in order. Depends on sts_pkg, sts_in_if and sts_out_if.
`timescale 1ns / 100ps

module sts_token_checker #(
	parameter int MAX_LEXEME    = 32,
	parameter int KEYWORD_COUNT = 14
) (
	input  logic clk,
	input  logic arst_n,
	sts_in_if    in_ch,
	sts_out_if   out_ch,
	output int   mismatches,
	output int   outstanding,
	output int   tokens_seen,
	output int   keywords_seen
);
	import sts_pkg::*;

	localparam int KW_USED = KEYWORD_COUNT < KW_TABLE ? KEYWORD_COUNT : KW_TABLE;

	string kw_spelling [KW_TABLE] = '{"bool", "char", "const", "string", "int", "if",
		"else", "while", "read", "print", "println", "main", "FALSE", "TRUE"};

	// Scanner state as the predictor sees it
	scan_state_t         st;
	int                  lex_n;
	logic [KW_TABLE-1:0] kw_live;
	logic [5:0]          held_kind;

	result_t step_out [2];
	int      step_n;
	result_t due_tokens [$];

	int n_bad = 0;
	int n_tok = 0;
	int n_kw  = 0;

	assign mismatches    = n_bad;
	assign outstanding   = due_tokens.size();
	assign tokens_seen   = n_tok;
	assign keywords_seen = n_kw;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [KW_TABLE-1:0] all_words();
		logic [KW_TABLE-1:0] m;
		m = '0;
		for (int i = 0; i < KW_USED; i++)
			m[i] = 1'b1;
		return m;
	endfunction

	function automatic int len_plus_one();
		return lex_n < MAX_LEXEME ? lex_n + 1 : MAX_LEXEME;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: token check: %s", $time, msg);
		n_bad++;
	endtask

	task automatic add_token(input logic [5:0] kind, input int len, input logic [7:0] errc);
		if (step_n < 2) begin
			step_out[step_n].kind     = kind;
			step_out[step_n].length   = len[5:0];
			step_out[step_n].err_char = errc;
			step_out[step_n].last     = 1'b0;
			step_n++;
		end
	endtask

	// Append one character to the lexeme and narrow the reserved-word candidates
	task automatic take_char(input logic [7:0] c);
		if (lex_n >= MAX_LEXEME) begin
			kw_live = '0;
			return;
		end
		for (int i = 0; i < KW_USED; i++)
			if (lex_n >= kw_spelling[i].len() || kw_spelling[i][lex_n] != c)
				kw_live[i] = 1'b0;
		lex_n++;
	endtask

	task automatic close_ident();
		logic [5:0] kind;
		kind = K_ID;
		for (int i = 0; i < KW_USED; i++)
			if (kw_live[i] && kw_spelling[i].len() == lex_n)
				kind = 6'(K_KW0 + i);
		add_token(kind, lex_n, 8'd0);
	endtask

	task automatic hold_single(input logic [7:0] c, input logic [5:0] kind);
		take_char(c);
		held_kind = kind;
		st = S_READY;
	endtask

	task automatic lex_restart(input logic [7:0] c);
		lex_n = 0;
		kw_live = all_words();
		held_kind = K_ID;
		st = S_START;
		if (c == CH_SP || c == CH_TAB || c == CH_NL)
			return;
		if (is_letter(c)) begin
			st = S_ID;
			take_char(c);
		end else if (is_num(c)) begin
			st = S_NUM;
			take_char(c);
		end else begin
			case (c)
				CH_DQUOTE: st = S_STR;
				CH_SQUOTE: st = S_CBEG;
				CH_EQ: begin
					st = S_EQ;
					take_char(c);
				end
				CH_BANG: begin
					st = S_NEQ;
					take_char(c);
				end
				CH_LT: begin
					st = S_LT;
					take_char(c);
				end
				CH_GT: begin
					st = S_GT;
					take_char(c);
				end
				CH_SLASH: begin
					st = S_SLASH;
					take_char(c);
				end
				CH_PLUS:   hold_single(c, K_PLUS);
				CH_MINUS:  hold_single(c, K_MINUS);
				CH_STAR:   hold_single(c, K_TIMES);
				CH_PCT:    hold_single(c, K_MOD);
				CH_LPAREN: hold_single(c, K_LPAREN);
				CH_RPAREN: hold_single(c, K_RPAREN);
				CH_LBRACE: hold_single(c, K_LBRACE);
				CH_RBRACE: hold_single(c, K_RBRACE);
				CH_COMMA:  hold_single(c, K_COMMA);
				CH_SEMI:   hold_single(c, K_SEMI);
				default:   add_token(K_ERR, 1, c);
			endcase
		end
	endtask

	// Second character of a possible two-character operator
	task automatic pair_op(input logic [7:0] c, input logic [5:0] pair_kind,
		input logic [5:0] single_kind);
		if (c == CH_EQ) begin
			add_token(pair_kind, len_plus_one(), 8'd0);
			lex_restart(CH_SP);
		end else if (single_kind == K_ERR) begin
			add_token(K_ERR, len_plus_one(), c);
			lex_restart(c);
		end else begin
			add_token(single_kind, lex_n, 8'd0);
			lex_restart(c);
		end
	endtask

	task automatic scan_char(input logic [7:0] c);
		case (st)
			S_ID: begin
				if (is_letter(c) || is_num(c)) begin
					take_char(c);
				end else begin
					close_ident();
					lex_restart(c);
				end
			end
			S_NUM: begin
				if (is_num(c)) begin
					take_char(c);
				end else if (is_letter(c)) begin
					add_token(K_ERR, len_plus_one(), c);
					lex_restart(c);
				end else begin
					add_token(K_NUM, lex_n, 8'd0);
					lex_restart(c);
				end
			end
			S_STR: begin
				if (c == CH_DQUOTE)
					held_kind = K_STR;
				else
					take_char(c);
				if (c == CH_DQUOTE)
					st = S_READY;
			end
			S_CBEG: begin
				take_char(c);
				st = S_CEND;
			end
			S_CEND: begin
				if (c == CH_SQUOTE) begin
					held_kind = K_CHR;
					st = S_READY;
				end else begin
					add_token(K_ERR, len_plus_one(), c);
					lex_restart(c);
				end
			end
			S_EQ:  pair_op(c, K_EQ, K_ASSIGN);
			S_NEQ: pair_op(c, K_NEQ, K_ERR);
			S_LT:  pair_op(c, K_LTEQ, K_LT);
			S_GT:  pair_op(c, K_GTEQ, K_GT);
			S_SLASH: begin
				if (c == CH_SLASH) begin
					take_char(c);
					st = S_LCOM;
				end else if (c == CH_STAR) begin
					take_char(c);
					st = S_BCOM;
				end else begin
					add_token(K_DIV, lex_n, 8'd0);
					lex_restart(c);
				end
			end
			S_LCOM: begin
				if (c == CH_NL) begin
					add_token(K_COM, lex_n, 8'd0);
					lex_restart(c);
				end else begin
					take_char(c);
				end
			end
			S_BCOM: begin
				take_char(c);
				if (c == CH_STAR)
					st = S_BSTAR;
			end
			S_BSTAR: begin
				// any run of stars followed by a slash closes the comment
				take_char(c);
				if (c == CH_SLASH) begin
					held_kind = K_COM;
					st = S_READY;
				end else if (c != CH_STAR) begin
					st = S_BCOM;
				end
			end
			S_READY: begin
				add_token(held_kind, lex_n, 8'd0);
				lex_restart(c);
			end
			default: lex_restart(c);
		endcase
	endtask

	task automatic scan_end_mark();
		case (st)
			S_ID:    close_ident();
			S_NUM:   add_token(K_NUM, lex_n, 8'd0);
			S_EQ:    add_token(K_ASSIGN, lex_n, 8'd0);
			S_LT:    add_token(K_LT, lex_n, 8'd0);
			S_GT:    add_token(K_GT, lex_n, 8'd0);
			S_SLASH: add_token(K_DIV, lex_n, 8'd0);
			S_LCOM:  add_token(K_COM, lex_n, 8'd0);
			S_READY: add_token(held_kind, lex_n, 8'd0);
			S_STR, S_CBEG, S_CEND, S_NEQ, S_BCOM, S_BSTAR:
				add_token(K_ERR, lex_n, 8'd0);
			default: ;
		endcase
		add_token(K_END, 0, 8'd0);
		lex_restart(CH_SP);
	endtask

	task automatic tokens_for_input(input logic [7:0] c, input logic eoi);
		step_n = 0;
		if (eoi)
			scan_end_mark();
		else
			scan_char(c);
		if (step_n > 0)
			step_out[step_n-1].last = 1'b1;
		for (int i = 0; i < step_n; i++)
			due_tokens.push_back(step_out[i]);
	endtask

	task automatic check_token();
		result_t want;
		if (due_tokens.size() == 0) begin
			report($sformatf("unexpected token kind %0d length %0d",
				out_ch.token_kind, out_ch.token_length));
			return;
		end
		want = due_tokens.pop_front();
		if (out_ch.token_kind != want.kind)
			report($sformatf("token %0d kind: expected %0d, got %0d",
				n_tok, want.kind, out_ch.token_kind));
		if (out_ch.token_length != want.length)
			report($sformatf("token %0d length: expected %0d, got %0d",
				n_tok, want.length, out_ch.token_length));
		if (out_ch.error_char != want.err_char)
			report($sformatf("token %0d error_char: expected %0d, got %0d",
				n_tok, want.err_char, out_ch.error_char));
		if (out_ch.last_of_run != want.last)
			report($sformatf("token %0d last_of_run: expected %0d, got %0d",
				n_tok, want.last, out_ch.last_of_run));
		if (want.kind >= K_KW0 && want.kind < K_END)
			n_kw++;
		n_tok++;
	endtask

	// Check the output first: a token leaving now never belongs to the
	// character accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_restart(CH_SP);
			due_tokens.delete();
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_token();
			if (in_ch.valid && in_ch.ready)
				tokens_for_input(in_ch.char_code, in_ch.end_of_input);
		end
	end

endmodule

@@ test/source_token_scanner_unit_tb.sv @@
// Top of the source token scanner testbench: clock, reset, character
// stimulus, token receiver and verdict. Depends on sts_pkg, the channel
// interfaces, source_token_scanner_unit and sts_token_checker.
`timescale 1ns / 100ps

module source_token_scanner_unit_tb;
	import sts_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sts_in_if  char_in ();
	sts_out_if token_out ();

	int fails, left, n_tokens, n_keywords;

	// Stimulus knobs shared between the sender and the receiver
	bit quiet_in   = 1'b0;
	bit quiet_out  = 1'b0;
	bit choke_req  = 1'b0;
	int items_sent = 0;

	string reserved [14] = '{"bool", "char", "const", "string", "int", "if",
		"else", "while", "read", "print", "println", "main", "FALSE", "TRUE"};
	string op_text [19] = '{"+", "-", "*", "%", "(", ")", "{", "}", ",", ";",
		"=", "==", "!=", "<", "<=", ">", ">=", "/", "!"};

	source_token_scanner_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.token_out (token_out)
	);

	sts_token_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (char_in),
		.out_ch        (token_out),
		.mismatches    (fails),
		.outstanding   (left),
		.tokens_seen   (n_tokens),
		.keywords_seen (n_keywords)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#2_400_000;
		$display("source_token_scanner_unit_tb: FAIL");
		$finish;
	end

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(0, 3) == 0)
			return 8'("0" + $urandom_range(0, 9));
		return rand_letter();
	endfunction

	function automatic logic [7:0] rand_byte_but(input logic [7:0] ex);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ex);
		return b;
	endfunction

	// Mostly short lexemes; once in a while one of 30 to 40 characters, near or past the length limit
	function automatic int rand_len(input int lo, input int hi);
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(30, 40);
		return $urandom_range(lo, hi);
	endfunction

	// Offer one character (or end mark) after a random gap and hold it until
	// the transfer. Enter and leave at a falling edge.
	task automatic send(input logic [7:0] c, input logic eoi);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			char_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_in.valid        <= 1'b1;
		char_in.char_code    <= c;
		char_in.end_of_input <= eoi;
		do
			@(posedge clk);
		while (!char_in.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	// One lexeme with random content, well formed most of the time,
	// followed by an optional separator.
	task automatic gen_lexeme();
		int    pick, n;
		string w;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			// reserved word, sometimes cut short or extended
			w = reserved[$urandom_range(0, 13)];
			case ($urandom_range(0, 3))
				0: w = w.substr(0, w.len() - 2);
				1: w = {w, "x"};
				default: ;
			endcase
			send_text(w);
		end else if (pick < 26) begin
			n = rand_len(1, 8);
			send(rand_letter(), 1'b0);
			repeat (n - 1) send(rand_alnum(), 1'b0);
		end else if (pick < 36) begin
			n = rand_len(1, 5);
			repeat (n) send(8'("0" + $urandom_range(0, 9)), 1'b0);
			// a letter right after digits is an error, then rescanned
			if ($urandom_range(0, 3) == 0)
				send(rand_letter(), 1'b0);
		end else if (pick < 46) begin
			send(CH_DQUOTE, 1'b0);
			n = rand_len(0, 6);
			repeat (n) send(rand_byte_but(CH_DQUOTE), 1'b0);
			if ($urandom_range(0, 9) == 0)
				send(8'($urandom), 1'b1);
			else
				send(CH_DQUOTE, 1'b0);
		end else if (pick < 53) begin
			send(CH_SQUOTE, 1'b0);
			if ($urandom_range(0, 9) == 0) begin
				send(8'($urandom), 1'b1);
			end else begin
				send(8'($urandom), 1'b0);
				if ($urandom_range(0, 4) == 0)
					send(rand_byte_but(CH_SQUOTE), 1'b0);
				else
					send(CH_SQUOTE, 1'b0);
			end
		end else if (pick < 59) begin
			send_text("//");
			n = rand_len(0, 8);
			repeat (n) send(rand_byte_but(CH_NL), 1'b0);
			if ($urandom_range(0, 5) == 0)
				send(8'($urandom), 1'b1);
			else
				send(CH_NL, 1'b0);
		end else if (pick < 66) begin
			send_text("/*");
			n = rand_len(0, 8);
			repeat (n) send(($urandom_range(0, 3) == 0) ? CH_STAR : rand_byte_but(CH_SLASH),
				1'b0);
			if ($urandom_range(0, 9) == 0) begin
				send(8'($urandom), 1'b1);
			end else begin
				repeat ($urandom_range(1, 3)) send(CH_STAR, 1'b0);
				send(CH_SLASH, 1'b0);
			end
		end else if (pick < 88) begin
			send_text(op_text[$urandom_range(0, 18)]);
		end else if (pick < 96) begin
			send(8'($urandom), 1'b0);
		end else begin
			send(8'($urandom), 1'b1);
		end
		case ($urandom_range(0, 5))
			0: send(CH_SP, 1'b0);
			1: send(CH_TAB, 1'b0);
			2: send(CH_NL, 1'b0);
			default: ;
		endcase
	endtask

	// Token receiver: random stalls, plus long hold-offs on request so the
	// result queue fills and the block pushes back on its input.
	initial begin
		int stall, hold;
		token_out.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (choke_req) begin
				token_out.ready <= 1'b0;
				hold = 80;
				while (hold > 0) begin
					@(negedge clk);
					hold--;
				end
				choke_req = 1'b0;
			end
			stall = quiet_out ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				token_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			token_out.ready <= 1'b1;
			do
				@(posedge clk);
			while (!token_out.valid);
			@(negedge clk);
		end
	end

	// Character sender and verdict
	initial begin
		int next_mood, next_choke, chokes, guard;
		char_in.valid        = 1'b0;
		char_in.char_code    = 8'd0;
		char_in.end_of_input = 1'b0;
		next_mood  = 120;
		next_choke = 300;
		chokes     = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: keyword, number then letter, lone bang, char constant,
		// string, empty block comment, top and bottom bytes, end mark,
		// unterminated string at end.
		send_text("TRUE 7q!x'a'\"s\"/**/");
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		send(8'h00, 1'b1);
		send(CH_DQUOTE, 1'b0);
		send(8'hFF, 1'b1);

		// Random token stream; switch idling on and off by phase and hold the
		// receiver off twice.
		while (items_sent < 850) begin
			if (items_sent >= next_mood) begin
				quiet_in  = ($urandom_range(0, 3) == 0);
				quiet_out = ($urandom_range(0, 3) == 0);
				next_mood += 120;
			end
			if (items_sent >= next_choke && chokes < 2) begin
				choke_req = 1'b1;
				chokes++;
				next_choke += 300;
			end
			gen_lexeme();
		end
		char_in.valid <= 1'b0;

		// Drain: wait for every expected token, then keep watching for strays
		guard = 0;
		while (left != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);

		$display("Scanned %0d input items into %0d checked tokens, %0d reserved words,",
			items_sent, n_tokens, n_keywords);
		$display("with random gaps on both sides and %0d long output hold-offs.", chokes);
		if (left != 0)
			$display("%0d expected tokens never arrived", left);
		if (fails == 0 && left == 0)
			$display("source_token_scanner_unit_tb: PASS");
		else
			$display("source_token_scanner_unit_tb: FAIL");
		$finish;
	end

endmodule
